// ===== src/turn_signal_telltale_controller_core_assert.svh =====
// Assertion macros for the turn signal telltale controller.
// Used by turn_signal_telltale_controller_core; needs clk_i and rst_ni in scope.
`ifndef TURN_SIGNAL_TELLTALE_CONTROLLER_CORE_ASSERT_SVH
`define TURN_SIGNAL_TELLTALE_CONTROLLER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TSTC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tstc assertion failed");
`define TSTC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("tstc assertion failed");
`else
`define TSTC_ASSERT(label, prop)
`define TSTC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== src/tstc_pkg.sv =====
// Shared codes and types of the turn signal telltale controller.
// No dependencies; used by tstc_step, tstc_out_reg, the core and the bench.
`timescale 1ns / 1ps
`default_nettype none
package tstc_pkg;

  localparam int unsigned DelayW = 8;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_LEFT  = 2'd1;
  localparam logic [1:0] MODE_RIGHT = 2'd2;

  localparam logic [1:0] LAMP_OFF     = 2'd0;
  localparam logic [1:0] LAMP_ON      = 2'd1;
  localparam logic [1:0] LAMP_OFF_REQ = 2'd2;
  localparam logic [1:0] LAMP_ON_REQ  = 2'd3;

  localparam logic [1:0] SOUND_NONE = 2'd0;
  localparam logic [1:0] SOUND_TICK = 2'd1;
  localparam logic [1:0] SOUND_TACK = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [1:0]        left_st;
    logic [1:0]        right_st;
    logic [DelayW-1:0] count;
  } state_t;

  typedef struct packed {
    logic [1:0] sound_request;
    logic       left_lamp_write;
    logic       left_lamp_value;
    logic       right_lamp_write;
    logic       right_lamp_value;
  } res_t;

endpackage
`default_nettype wire

// ===== src/tstc_req_if.sv =====
// Request channel of the turn signal telltale controller.
// Carries the left and right request bits with a valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface tstc_req_if;
  logic valid;
  logic ready;
  logic left_request;
  logic right_request;

  modport source (output valid, output left_request, output right_request, input ready);
  modport sink (input valid, input left_request, input right_request, output ready);
endinterface
`default_nettype wire

// ===== src/tstc_res_if.sv =====
// Result channel of the turn signal telltale controller.
// Carries the sound request and both lamp writes with a valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface tstc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] sound_request;
  logic       left_lamp_write;
  logic       left_lamp_value;
  logic       right_lamp_write;
  logic       right_lamp_value;

  modport source (
    output valid, output sound_request, output left_lamp_write, output left_lamp_value,
    output right_lamp_write, output right_lamp_value, input ready
  );
  modport sink (
    input valid, input sound_request, input left_lamp_write, input left_lamp_value,
    input right_lamp_write, input right_lamp_value, output ready
  );
endinterface
`default_nettype wire

// ===== src/tstc_in_reg.sv =====
// Input register stage: captures one request transfer per cycle unless stalled.
// Depends on tstc_req_if.
`timescale 1ns / 1ps
`default_nettype none
module tstc_in_reg (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tstc_req_if.sink  req_i,
  input  wire logic adv_i,
  output logic      valid_o,
  output logic      left_o,
  output logic      right_o
);

  logic valid_q;
  logic left_q;
  logic right_q;

  assign req_i.ready = !valid_q || adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      left_q  <= req_i.left_request;
      right_q <= req_i.right_request;
    end
  end

  assign valid_o = valid_q;
  assign left_o  = left_q;
  assign right_o = right_q;

endmodule
`default_nettype wire

// ===== src/tstc_step.sv =====
// Step logic: indication machine, then left and right lamp machines.
// Depends on tstc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tstc_step (
  input  wire tstc_pkg::state_t        state_i,
  input  wire logic                    left_i,
  input  wire logic                    right_i,
  input  wire logic [tstc_pkg::DelayW-1:0] delay_i,
  output tstc_pkg::state_t             state_o,
  output tstc_pkg::res_t               res_o
);

  tstc_pkg::state_t st;
  tstc_pkg::res_t   rs;

  always_comb begin
    st = state_i;
    rs = '0;
    rs.sound_request = tstc_pkg::SOUND_NONE;

    unique case (state_i.mode)
      tstc_pkg::MODE_IDLE: begin
        if (left_i) begin
          rs.sound_request    = tstc_pkg::SOUND_TICK;
          st.count            = delay_i;
          st.left_st          = tstc_pkg::LAMP_ON_REQ;
          rs.right_lamp_write = 1'b1;
          st.right_st         = tstc_pkg::LAMP_OFF;
          st.mode             = tstc_pkg::MODE_LEFT;
        end else if (right_i) begin
          rs.sound_request    = tstc_pkg::SOUND_TICK;
          st.count            = delay_i;
          st.right_st         = tstc_pkg::LAMP_ON_REQ;
          rs.left_lamp_write  = 1'b1;
          st.left_st          = tstc_pkg::LAMP_OFF;
          st.mode             = tstc_pkg::MODE_RIGHT;
        end
      end
      tstc_pkg::MODE_LEFT: begin
        if (!left_i) begin
          rs.sound_request = tstc_pkg::SOUND_TACK;
          st.count         = delay_i;
          st.left_st       = tstc_pkg::LAMP_OFF_REQ;
          st.mode          = tstc_pkg::MODE_IDLE;
        end
      end
      tstc_pkg::MODE_RIGHT: begin
        if (!right_i) begin
          rs.sound_request = tstc_pkg::SOUND_TACK;
          st.count         = delay_i;
          st.right_st      = tstc_pkg::LAMP_OFF_REQ;
          st.mode          = tstc_pkg::MODE_IDLE;
        end
      end
      default: begin
      end
    endcase

    // left lamp first, then right; both share the counter
    if (st.left_st == tstc_pkg::LAMP_OFF_REQ || st.left_st == tstc_pkg::LAMP_ON_REQ) begin
      if (st.count == '0) begin
        rs.left_lamp_write = 1'b1;
        rs.left_lamp_value = (st.left_st == tstc_pkg::LAMP_ON_REQ);
        st.left_st = rs.left_lamp_value ? tstc_pkg::LAMP_ON : tstc_pkg::LAMP_OFF;
      end else begin
        st.count = st.count - {{(tstc_pkg::DelayW-1){1'b0}}, 1'b1};
      end
    end

    if (st.right_st == tstc_pkg::LAMP_OFF_REQ || st.right_st == tstc_pkg::LAMP_ON_REQ) begin
      if (st.count == '0) begin
        rs.right_lamp_write = 1'b1;
        rs.right_lamp_value = (st.right_st == tstc_pkg::LAMP_ON_REQ);
        st.right_st = rs.right_lamp_value ? tstc_pkg::LAMP_ON : tstc_pkg::LAMP_OFF;
      end else begin
        st.count = st.count - {{(tstc_pkg::DelayW-1){1'b0}}, 1'b1};
      end
    end
  end

  assign state_o = st;
  assign res_o   = rs;

endmodule
`default_nettype wire

// ===== src/tstc_out_reg.sv =====
// Result register: holds one result until the sink takes the transfer.
// Depends on tstc_pkg and tstc_res_if.
`timescale 1ns / 1ps
`default_nettype none
module tstc_out_reg (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire tstc_pkg::res_t res_i,
  output logic           stall_o,
  tstc_res_if.source     res_o
);

  logic           valid_q;
  tstc_pkg::res_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign stall_o                = valid_q && !res_o.ready;
  assign res_o.valid            = valid_q;
  assign res_o.sound_request    = data_q.sound_request;
  assign res_o.left_lamp_write  = data_q.left_lamp_write;
  assign res_o.left_lamp_value  = data_q.left_lamp_value;
  assign res_o.right_lamp_write = data_q.right_lamp_write;
  assign res_o.right_lamp_value = data_q.right_lamp_value;

endmodule
`default_nettype wire

// ===== src/turn_signal_telltale_controller_core.sv =====
// Turn signal telltale controller: one request in, one sound/lamp result out per transfer.
// Throughput is one transfer per cycle unless the result sink stalls. Path: input
// register, step logic, result register. Indication and lamp state advance once per
// request in the step stage, so back-to-back requests see each other's effects in order.
// The user must write lamp_delay through cfg_we_i/cfg_data_i only while idle; not enforced.
// Depends on tstc_pkg, tstc_req_if, tstc_res_if, tstc_in_reg, tstc_step, tstc_out_reg.
`timescale 1ns / 1ps
`default_nettype none
`include "turn_signal_telltale_controller_core_assert.svh"
module turn_signal_telltale_controller_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tstc_pkg::DelayW-1:0] cfg_data_i,
  tstc_req_if.sink                         req_i,
  tstc_res_if.source                       res_o
);

  logic                        s1_valid;
  logic                        s1_left;
  logic                        s1_right;
  logic                        out_stall;
  logic                        adv;
  logic [tstc_pkg::DelayW-1:0] lamp_delay_q;
  tstc_pkg::state_t            state_q;
  tstc_pkg::state_t            state_d;
  tstc_pkg::res_t              res_d;

  assign adv = s1_valid && !out_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lamp_delay_q <= '0;
    end else if (cfg_we_i) begin
      lamp_delay_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode     <= tstc_pkg::MODE_IDLE;
      state_q.left_st  <= tstc_pkg::LAMP_OFF;
      state_q.right_st <= tstc_pkg::LAMP_OFF;
      state_q.count    <= '0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  tstc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .adv_i   (adv),
    .valid_o (s1_valid),
    .left_o  (s1_left),
    .right_o (s1_right)
  );

  tstc_step u_step (
    .state_i (state_q),
    .left_i  (s1_left),
    .right_i (s1_right),
    .delay_i (lamp_delay_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  tstc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .res_i   (res_d),
    .stall_o (out_stall),
    .res_o   (res_o)
  );

  `TSTC_ASSERT(a_tick_enters_side,
    adv |=> (res_o.sound_request != tstc_pkg::SOUND_TICK || state_q.mode != tstc_pkg::MODE_IDLE))
  `TSTC_ASSERT(a_ready_low_only_on_stall,
    !req_i.ready |-> (s1_valid && res_o.valid && !res_o.ready))
  `TSTC_ASSERT_ALWAYS(a_one_side_lit,
    !((state_q.left_st == tstc_pkg::LAMP_ON || state_q.left_st == tstc_pkg::LAMP_ON_REQ) &&
      (state_q.right_st == tstc_pkg::LAMP_ON || state_q.right_st == tstc_pkg::LAMP_ON_REQ)))

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for turn_signal_telltale_controller_core: random request ticks,
// per-phase lamp delay, result checks against an in-bench predictor.
// Depends on tstc_pkg, tstc_req_if, tstc_res_if and the core RTL.
`timescale 1ns / 1ps
module tb_top;
  import tstc_pkg::*;

  localparam int unsigned HoldCycles = 100;
  localparam int unsigned IdleLimit  = 5000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [DelayW-1:0] cfg_data_i;

  tstc_req_if req_if ();
  tstc_res_if res_if ();

  turn_signal_telltale_controller_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  // bit 1 = left request, bit 0 = right request
  logic [1:0] request_q[$];
  res_t       telltale_exp_q[$];

  logic [1:0]        ind_mode;
  logic [1:0]        left_lamp_st;
  logic [1:0]        right_lamp_st;
  logic [DelayW-1:0] delay_cnt;
  logic [DelayW-1:0] lamp_delay_q;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_request;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned idle_cycles;
  int unsigned mismatch_cnt;

  function automatic void settle_lamp(inout logic [1:0] st, inout logic wr, inout logic val);
    if (st == LAMP_OFF_REQ || st == LAMP_ON_REQ) begin
      if (delay_cnt == '0) begin
        wr  = 1'b1;
        val = (st == LAMP_ON_REQ);
        st  = (st == LAMP_ON_REQ) ? LAMP_ON : LAMP_OFF;
      end else begin
        delay_cnt = delay_cnt - 1'b1;
      end
    end
  endfunction

  function automatic res_t telltale_outputs(logic left, logic right);
    res_t r;
    r = '0;
    r.sound_request = SOUND_NONE;
    case (ind_mode)
      MODE_IDLE: begin
        if (left) begin
          r.sound_request = SOUND_TICK;
          delay_cnt = lamp_delay_q;
          left_lamp_st = LAMP_ON_REQ;
          r.right_lamp_write = 1'b1;
          r.right_lamp_value = 1'b0;
          right_lamp_st = LAMP_OFF;
          ind_mode = MODE_LEFT;
        end else if (right) begin
          r.sound_request = SOUND_TICK;
          delay_cnt = lamp_delay_q;
          right_lamp_st = LAMP_ON_REQ;
          r.left_lamp_write = 1'b1;
          r.left_lamp_value = 1'b0;
          left_lamp_st = LAMP_OFF;
          ind_mode = MODE_RIGHT;
        end
      end
      MODE_LEFT: begin
        if (!left) begin
          r.sound_request = SOUND_TACK;
          delay_cnt = lamp_delay_q;
          left_lamp_st = LAMP_OFF_REQ;
          ind_mode = MODE_IDLE;
        end
      end
      MODE_RIGHT: begin
        if (!right) begin
          r.sound_request = SOUND_TACK;
          delay_cnt = lamp_delay_q;
          right_lamp_st = LAMP_OFF_REQ;
          ind_mode = MODE_IDLE;
        end
      end
      default: ;
    endcase
    settle_lamp(left_lamp_st, r.left_lamp_write, r.left_lamp_value);
    settle_lamp(right_lamp_st, r.right_lamp_write, r.right_lamp_value);
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // driver: present the next pending tick once the current one has transferred
  always @(posedge clk_i) begin : drive_requests
    if (req_if.valid && req_if.ready)
      telltale_exp_q.push_back(telltale_outputs(req_if.left_request, req_if.right_request));
    if (!req_if.valid || req_if.ready) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_if.valid         <= 1'b1;
        req_if.left_request  <= request_q[0][1];
        req_if.right_request <= request_q[0][0];
        void'(request_q.pop_front());
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : watch_results
    res_t exp_r;
    if (res_if.valid && res_if.ready) begin
      if (telltale_exp_q.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $time);
        mismatch_cnt++;
      end else begin
        exp_r = telltale_exp_q.pop_front();
        check_field("sound_request", exp_r.sound_request, res_if.sound_request);
        check_field("left_lamp_write", exp_r.left_lamp_write, res_if.left_lamp_write);
        check_field("left_lamp_value", exp_r.left_lamp_value, res_if.left_lamp_value);
        check_field("right_lamp_write", exp_r.right_lamp_write, res_if.right_lamp_write);
        check_field("right_lamp_value", exp_r.right_lamp_value, res_if.right_lamp_value);
      end
    end
    if (hold_seen != hold_request) begin
      hold_seen    <= hold_request;
      hold_left    <= HoldCycles;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_delay(logic [DelayW-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    lamp_delay_q = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || req_if.valid || telltale_exp_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // mostly held sides with random run lengths, the rest both/none and bit noise
  task automatic add_runs(int unsigned n, int unsigned maxlen);
    int unsigned left_n;
    int unsigned len;
    int unsigned pick;
    logic [1:0]  pat;
    left_n = n;
    while (left_n > 0) begin
      pick = $urandom_range(9);
      if (pick < 5) pat = $urandom_range(1) ? 2'b10 : 2'b01;
      else if (pick < 7) pat = 2'b00;
      else if (pick < 8) pat = 2'b11;
      else pat = 2'bxx;
      len = $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(1, maxlen);
      if (len > left_n) len = left_n;
      repeat (len) begin
        request_q.push_back((pat === 2'bxx) ? 2'($urandom_range(3)) : pat);
      end
      left_n -= len;
    end
  endtask

  task automatic run_phase(logic [DelayW-1:0] dly, int unsigned s_pct, int unsigned r_pct,
                           int unsigned n, bit pressure);
    write_delay(dly);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    add_runs(n, int'(dly) + 4);
    if (pressure) begin
      repeat (20) @(negedge clk_i);
      hold_request++;
    end
    wait_drained();
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_data_i           = '0;
    req_if.valid         = 1'b0;
    req_if.left_request  = 1'b0;
    req_if.right_request = 1'b0;
    res_if.ready         = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    hold_request         = 0;
    hold_seen            = 0;
    hold_left            = 0;
    idle_cycles          = 0;
    mismatch_cnt         = 0;
    ind_mode             = MODE_IDLE;
    left_lamp_st         = LAMP_OFF;
    right_lamp_st        = LAMP_OFF;
    delay_cnt            = '0;
    lamp_delay_q         = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset delay: both from idle, ignored side while active, release and switch
    request_q = '{2'b00, 2'b11, 2'b11, 2'b01, 2'b00, 2'b01, 2'b11, 2'b10,
                  2'b10, 2'b00, 2'b01, 2'b00, 2'b11, 2'b00};
    wait_drained();
    // short delay: pending writes, release while pending, switch cancels pending
    write_delay(8'd2);
    request_q = '{2'b10, 2'b10, 2'b10, 2'b10, 2'b00, 2'b00, 2'b00, 2'b00,
                  2'b10, 2'b00, 2'b10, 2'b10, 2'b00, 2'b01};
    wait_drained();

    run_phase(8'd1, 0, 0, 300, 1'b1);
    run_phase(8'd255, 78, 0, 400, 1'b0);
    run_phase(8'd3, 0, 78, 400, 1'b0);
    run_phase(8'($urandom_range(0, 15)), 35, 35, 300, 1'b0);
    run_phase(8'd0, 0, 0, 250, 1'b0);

    if (telltale_exp_q.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
